// File: rtl/core/mp3d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3d_pkg
// Shared types and constants for the 2x2x2 3-D max pooling block.
// ----------------------------------------------------------------------------
package mp3d_pkg;

	// Width of each dimension register
	localparam int DIM_W = 11;
	// Configuration bus widths
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DEPTH  = 2'd2;
	localparam logic [1:0] REG_SIGNED = 2'd3;

	// Register file contents handed to the datapath
	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [DIM_W-1:0] depth;
		logic             sample_signed;
	} vol_cfg_t;

endpackage

// File: rtl/core/mp3d_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3d_cfg
// APB-style register file: volume dimensions and sample signedness.
// ----------------------------------------------------------------------------
module mp3d_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mp3d_pkg::PADDR_W-1:0] paddr,
	input  logic [mp3d_pkg::PDATA_W-1:0] pwdata,
	output logic [mp3d_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	output mp3d_pkg::vol_cfg_t            cfg
);

	mp3d_pkg::vol_cfg_t cfg_q;
	logic               wr_en;
	logic [1:0]         reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Write registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width         <= mp3d_pkg::DIM_W'(1);
			cfg_q.height        <= mp3d_pkg::DIM_W'(1);
			cfg_q.depth         <= mp3d_pkg::DIM_W'(1);
			cfg_q.sample_signed <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				mp3d_pkg::REG_WIDTH:  cfg_q.width         <= pwdata[mp3d_pkg::DIM_W-1:0];
				mp3d_pkg::REG_HEIGHT: cfg_q.height        <= pwdata[mp3d_pkg::DIM_W-1:0];
				mp3d_pkg::REG_DEPTH:  cfg_q.depth         <= pwdata[mp3d_pkg::DIM_W-1:0];
				mp3d_pkg::REG_SIGNED: cfg_q.sample_signed <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		prdata = '0;
		case (reg_idx)
			mp3d_pkg::REG_WIDTH:  prdata = mp3d_pkg::PDATA_W'(cfg_q.width);
			mp3d_pkg::REG_HEIGHT: prdata = mp3d_pkg::PDATA_W'(cfg_q.height);
			mp3d_pkg::REG_DEPTH:  prdata = mp3d_pkg::PDATA_W'(cfg_q.depth);
			mp3d_pkg::REG_SIGNED: prdata = mp3d_pkg::PDATA_W'(cfg_q.sample_signed);
			default:              prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/max_pool_3d_2x2x2.sv
`timescale 1ns / 1ps
// Accepted items are registered in the merge stage, block results then in the output register.
// Throughput: one item per cycle unless the output register stalls; the plane memory does one
//   read (at accept) and one write (item leaving merge stage) per cycle, back-to-back hits forwarded.
// Reset clears counters, handshake state and registers (dims 1, unsigned);
//   the partial-max plane needs no clearing, each entry is written by its block's first item.
// ----------------------------------------------------------------------------
// max_pool_3d_2x2x2
// Streams a raster-order volume and emits the max (floored at zero) of each
// 2x2x2 block, using a plane memory of running partial maxima.
// ----------------------------------------------------------------------------
module max_pool_3d_2x2x2 #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_HEIGHT  = 1024,
	parameter int MAX_DEPTH   = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mp3d_pkg::PADDR_W-1:0] paddr,
	input  logic [mp3d_pkg::PDATA_W-1:0] pwdata,
	output logic [mp3d_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [SAMPLE_BITS-1:0]        sample_bits,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [SAMPLE_BITS-1:0]        pooled_value,
	output logic                          last_of_volume
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int ZW  = $clog2(MAX_DEPTH);
	localparam int CHW = (CW > 1) ? CW - 1 : 1;
	localparam int RHW = (RW > 1) ? RW - 1 : 1;
	localparam int AW  = CHW + RHW;
	localparam int PLANE_DEPTH = 1 << AW;

	mp3d_pkg::vol_cfg_t cfg;

	mp3d_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Clamped last index of each dimension
	logic [CW-1:0] w_last;
	logic [RW-1:0] h_last;
	logic [ZW-1:0] d_last;
	logic [31:0]   w_wide, h_wide, d_wide;

	assign w_wide = 32'(cfg.width);
	assign h_wide = 32'(cfg.height);
	assign d_wide = 32'(cfg.depth);

	always_comb begin
		if (w_wide == 32'd0)                 w_last = '0;
		else if (w_wide > 32'(MAX_WIDTH))    w_last = CW'(MAX_WIDTH - 1);
		else                                 w_last = CW'(w_wide - 32'd1);
		if (h_wide == 32'd0)                 h_last = '0;
		else if (h_wide > 32'(MAX_HEIGHT))   h_last = RW'(MAX_HEIGHT - 1);
		else                                 h_last = RW'(h_wide - 32'd1);
		if (d_wide == 32'd0)                 d_last = '0;
		else if (d_wide > 32'(MAX_DEPTH))    d_last = ZW'(MAX_DEPTH - 1);
		else                                 d_last = ZW'(d_wide - 32'd1);
	end

	// Position counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [ZW-1:0] slice_q;
	logic          x_end, y_end, z_end;
	logic          blk_done, blk_first;
	logic          in_accept;
	logic [SAMPLE_BITS-1:0] samp_in;
	logic [AW-1:0]          addr_in;

	assign x_end     = col_q >= w_last;
	assign y_end     = row_q >= h_last;
	assign z_end     = slice_q >= d_last;
	assign blk_done  = (col_q[0] || x_end) && (row_q[0] || y_end) && (slice_q[0] || z_end);
	assign blk_first = !col_q[0] && !row_q[0] && !slice_q[0];
	assign in_accept = in_valid && in_ready;
	assign addr_in   = {RHW'(row_q >> 1), CHW'(col_q >> 1)};

	// Floor negative signed samples at zero
	assign samp_in = (cfg.sample_signed && sample_bits[SAMPLE_BITS-1]) ? '0 : sample_bits;

	// Advance raster position on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
		end else if (in_accept) begin
			if (x_end) begin
				col_q <= '0;
				if (y_end) begin
					row_q <= '0;
					slice_q <= z_end ? '0 : slice_q + ZW'(1);
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Merge stage
	logic                   valid_s1, emit_s1, last_s1, first_s1, fwd_s1;
	logic [SAMPLE_BITS-1:0] samp_s1, rd_s1, fwd_data_s1;
	logic [AW-1:0]          addr_s1;
	logic [SAMPLE_BITS-1:0] base_s1, merged_s1;
	logic                   advance_s1;
	logic                   out_valid_q, out_last_q;
	logic [SAMPLE_BITS-1:0] out_value_q;

	assign base_s1    = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign merged_s1  = first_s1 ? samp_s1 : ((samp_s1 > base_s1) ? samp_s1 : base_s1);
	assign advance_s1 = valid_s1 && (!emit_s1 || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	// Plane memory: read at accept, write back when the merge stage drains
	logic [SAMPLE_BITS-1:0] plane_mem [PLANE_DEPTH];

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			plane_mem[addr_s1] <= merged_s1;
		end
		if (in_accept) begin
			rd_s1 <= plane_mem[addr_in];
		end
	end

	// Merge stage control; catch a write to the same entry on the read edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			emit_s1  <= 1'b0;
			last_s1  <= 1'b0;
			first_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= advance_s1 && (addr_s1 == addr_in);
			emit_s1  <= blk_done;
			last_s1  <= x_end && y_end && z_end;
			first_s1 <= blk_first;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end
	end

	// Merge stage payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			samp_s1     <= samp_in;
			addr_s1     <= addr_in;
			fwd_data_s1 <= merged_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit_s1) begin
			out_value_q <= merged_s1;
			out_last_q  <= last_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign pooled_value   = out_value_q;
	assign last_of_volume = out_last_q;

`ifndef SYNTHESIS
	// The final sample of a volume wraps every counter to zero
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && x_end && y_end && z_end |=> col_q == '0 && row_q == '0 && slice_q == '0)
		else $error("counters did not wrap after the last sample of the volume");

	// A result blocked by a full output register keeps the merge stage occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit_s1 && out_valid_q && !out_ready |=> valid_s1)
		else $error("result dropped while output register was full");

	// Forwarding only applies to an occupied merge stage
	assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forward flag set with empty merge stage");
`endif

endmodule

// File: verif/max_pool_3d_2x2x2_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_3d_2x2x2_tb
// Streams whole volumes through the 3-D max pooling block under a series of
// volume shapes and sample signedness settings. A local pooling model
// predicts every pooled voxel, and the monitor compares each one as it leaves.
// ----------------------------------------------------------------------------
module max_pool_3d_2x2x2_tb;

	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int MAX_DEPTH     = 1024;
	localparam int SAMPLE_BITS   = 16;
	localparam int PLANE_COLS    = (MAX_WIDTH + 1) / 2;
	localparam int PLANE_SIZE    = PLANE_COLS * ((MAX_HEIGHT + 1) / 2);
	localparam int SETTLE_CYCLES = 6;

	typedef struct {
		logic [SAMPLE_BITS-1:0] value;
		logic                   last;
	} pool_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [mp3d_pkg::PADDR_W-1:0]     paddr = '0;
	logic [mp3d_pkg::PDATA_W-1:0]     pwdata = '0;
	logic [mp3d_pkg::PDATA_W-1:0]     prdata;
	logic                             pready;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic [SAMPLE_BITS-1:0]           sample_bits = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic [SAMPLE_BITS-1:0]           pooled_value;
	logic                             last_of_volume;

	// Local copy of the register file
	logic [mp3d_pkg::DIM_W-1:0] cfg_width = mp3d_pkg::DIM_W'(1);
	logic [mp3d_pkg::DIM_W-1:0] cfg_height = mp3d_pkg::DIM_W'(1);
	logic [mp3d_pkg::DIM_W-1:0] cfg_depth = mp3d_pkg::DIM_W'(1);
	logic                       cfg_signed = 1'b0;

	// Pooling model state
	int unsigned            col_pos = 0;
	int unsigned            row_pos = 0;
	int unsigned            slice_pos = 0;
	logic [SAMPLE_BITS-1:0] partial_max [PLANE_SIZE];

	logic [SAMPLE_BITS-1:0] sample_queue [$];
	pool_result_t           pooled_expected [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned items_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned volumes_run = 0;
	int unsigned settings_run = 0;

	max_pool_3d_2x2x2 #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_DEPTH(MAX_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_bits(sample_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pooled_value(pooled_value),
		.last_of_volume(last_of_volume)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Map a dimension register to the size the block actually uses
	function automatic int unsigned effective_dim(input logic [mp3d_pkg::DIM_W-1:0] v,
			input int unsigned maxv);
		if (v == 0)
			return 1;
		if (32'(v) > maxv)
			return maxv;
		return 32'(v);
	endfunction

	// Fold one sample into the plane and queue the pooled voxel it completes
	task automatic pool_sample(input logic [SAMPLE_BITS-1:0] raw);
		int unsigned w;
		int unsigned h;
		int unsigned d;
		int unsigned cell_idx;
		logic [SAMPLE_BITS-1:0] s;
		logic [SAMPLE_BITS-1:0] merged;
		logic x_end;
		logic y_end;
		logic z_end;
		pool_result_t res;
		w = effective_dim(cfg_width, MAX_WIDTH);
		h = effective_dim(cfg_height, MAX_HEIGHT);
		d = effective_dim(cfg_depth, MAX_DEPTH);
		s = (cfg_signed && raw[SAMPLE_BITS-1]) ? '0 : raw;
		x_end = col_pos[0] || (col_pos >= w - 1);
		y_end = row_pos[0] || (row_pos >= h - 1);
		z_end = slice_pos[0] || (slice_pos >= d - 1);
		cell_idx = ((row_pos / 2) * PLANE_COLS + col_pos / 2) % PLANE_SIZE;
		if (!col_pos[0] && !row_pos[0] && !slice_pos[0]) begin
			merged = s;
		end else begin
			merged = (s > partial_max[cell_idx]) ? s : partial_max[cell_idx];
		end
		partial_max[cell_idx] = merged;
		if (x_end && y_end && z_end) begin
			res.value = merged;
			res.last = (col_pos >= w - 1) && (row_pos >= h - 1) && (slice_pos >= d - 1);
			pooled_expected.push_back(res);
		end
		// Advance the raster position
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) begin
				row_pos = 0;
				slice_pos++;
				if (slice_pos >= d)
					slice_pos = 0;
			end
		end
	endtask

	// Sender: hold each item until accepted, idle at random between items
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				pool_sample(sample_bits);
				items_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					sample_bits <= sample_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall at random, check each accepted pooled voxel
	always @(posedge clk) begin
		pool_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pooled_expected.size() == 0) begin
					$display("%0t: unexpected item, actual value %h last %b",
						$time, pooled_value, last_of_volume);
					mismatch_count++;
				end else begin
					want = pooled_expected.pop_front();
					if (pooled_value !== want.value) begin
						$display("%0t: pooled_value mismatch, expected %h actual %h",
							$time, want.value, pooled_value);
						mismatch_count++;
					end
					if (last_of_volume !== want.last) begin
						$display("%0t: last_of_volume mismatch, expected %b actual %b",
							$time, want.last, last_of_volume);
						mismatch_count++;
					end
				end
				results_checked++;
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(input logic [1:0] idx,
			input logic [mp3d_pkg::PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			mp3d_pkg::REG_WIDTH:  cfg_width = value[mp3d_pkg::DIM_W-1:0];
			mp3d_pkg::REG_HEIGHT: cfg_height = value[mp3d_pkg::DIM_W-1:0];
			mp3d_pkg::REG_DEPTH:  cfg_depth = value[mp3d_pkg::DIM_W-1:0];
			mp3d_pkg::REG_SIGNED: cfg_signed = value[0];
			default: ;
		endcase
	endtask

	task automatic set_volume(input int unsigned w, input int unsigned h,
			input int unsigned d, input bit sgn);
		write_reg(mp3d_pkg::REG_WIDTH, w);
		write_reg(mp3d_pkg::REG_HEIGHT, h);
		write_reg(mp3d_pkg::REG_DEPTH, d);
		write_reg(mp3d_pkg::REG_SIGNED, 32'(sgn));
		settings_run++;
	endtask

	// Wait for every item to go in and every pooled voxel to come out
	task automatic drain();
		while (sample_queue.size() != 0 || in_valid || pooled_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int unsigned kind);
		case (kind)
			0: return 16'($urandom_range(0, 65535));
			// near zero on both sides, lots of ties and negatives
			1: return 16'($urandom_range(0, 31) - 16);
			default: begin
				case ($urandom_range(0, 4))
					0: return 16'h0000;
					1: return 16'hFFFF;
					2: return 16'h7FFF;
					3: return 16'h8000;
					default: return 16'($urandom_range(0, 65535));
				endcase
			end
		endcase
	endfunction

	// Stream whole volumes of the current shape, return the item count
	task automatic stream_volumes(input int unsigned nvol, input int unsigned kind,
			output int unsigned count);
		count = nvol * effective_dim(cfg_width, MAX_WIDTH)
			* effective_dim(cfg_height, MAX_HEIGHT) * effective_dim(cfg_depth, MAX_DEPTH);
		for (int unsigned i = 0; i < count; i++)
			sample_queue.push_back(pick_sample(kind));
		volumes_run += nvol;
		drain();
	endtask

	initial begin
		int unsigned random_items;
		int unsigned goal;
		int unsigned count;
		random_items = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 38;
					recv_idle_pct = 72;
				end
				1: begin
					send_idle_pct = 72;
					recv_idle_pct = 38;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			if (mode == 0) begin
				// Reset shape 1x1x1 unsigned: every sample is its own voxel
				sample_queue.push_back(16'h0000);
				sample_queue.push_back(16'hFFFF);
				sample_queue.push_back(16'h8000);
				sample_queue.push_back(16'h7FFF);
				volumes_run += 4;
				drain();
				// Zero dimensions act as one; negative signed samples floor at zero
				set_volume(0, 0, 0, 1'b1);
				sample_queue.push_back(16'h8000);
				sample_queue.push_back(16'hFFFF);
				sample_queue.push_back(16'h7FFF);
				sample_queue.push_back(16'h0001);
				sample_queue.push_back(16'h0000);
				sample_queue.push_back(16'hC3A5);
				volumes_run += 6;
				drain();
				// One full 2x2x2 block
				set_volume(2, 2, 2, 1'b0);
				sample_queue.push_back(16'h0010);
				sample_queue.push_back(16'hFFFE);
				sample_queue.push_back(16'h0003);
				sample_queue.push_back(16'h0100);
				sample_queue.push_back(16'h0000);
				sample_queue.push_back(16'h8001);
				sample_queue.push_back(16'h0002);
				sample_queue.push_back(16'h7000);
				volumes_run += 1;
				drain();
				// Odd width leaves a partial block at the row end
				set_volume(3, 1, 1, 1'b1);
				sample_queue.push_back(16'hFFFF);
				sample_queue.push_back(16'h0005);
				sample_queue.push_back(16'h8000);
				volumes_run += 1;
				drain();
			end

			// Small random shapes, whole volumes only
			goal = random_items + 250;
			while (random_items < goal) begin
				set_volume($urandom_range(0, 9), $urandom_range(0, 7), $urandom_range(0, 6),
					$urandom_range(0, 1));
				stream_volumes($urandom_range(1, 3), $urandom_range(0, 2), count);
				random_items += count;
			end
		end

		drain();
		$display("Streamed %0d samples in %0d volumes over %0d register settings,",
			items_accepted, volumes_run, settings_run);
		$display("checked %0d pooled voxels, %0d mismatches.", results_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("** max_pool_3d_2x2x2: PASSED **");
		end else begin
			$display("** max_pool_3d_2x2x2: FAILED **");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(5_000_000);
		$display("Timeout with %0d pooled voxels outstanding", pooled_expected.size());
		$display("** max_pool_3d_2x2x2: FAILED **");
		$finish;
	end

endmodule
